>>> rtl/core/sliding_window_max_spread_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window max spread unit
// Clocked checks on clk, disabled while rst_n is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MAX_SPREAD_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_MAX_SPREAD_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define SWMS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swms assertion failed");
// antecedent implies consequent in the next cycle
`define SWMS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swms assertion failed");
`else
`define SWMS_ASSERT_IMPL(lbl, ante, cons)
`define SWMS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/core/swms_pkg.sv
// ----------------------------------------------------------------------------
// swms_pkg
// Shared types and constants of the sliding window max spread unit.
// ----------------------------------------------------------------------------
package swms_pkg;

    localparam int SAMPLE_W       = 32;
    localparam int LEN_W          = 9;
    localparam int WINDOW_MAX_DEF = 256;
    // cells reduced per first-level group of the tap tree
    localparam int GROUP_SIZE     = 16;

    localparam logic [LEN_W-1:0] LEN_RESET = 9'd1;

    // input item
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } swms_item_t;

    // result item
    typedef struct packed {
        logic [SAMPLE_W-1:0] best_spread;
        logic                window_seen;
    } swms_result_t;

    // per-item control carried down the tap pipeline
    typedef struct packed {
        logic valid;
        logic hit;
        logic last;
    } swms_tag_t;

endpackage

>>> rtl/core/swms_cell.sv
// ----------------------------------------------------------------------------
// swms_cell
// One suffix cell: running max and min of the last k+1 samples, built from
// the neighbor cell's values and the incoming sample.
// ----------------------------------------------------------------------------
module swms_cell (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [swms_pkg::SAMPLE_W-1:0] sample,
    input  logic signed [swms_pkg::SAMPLE_W-1:0] prev_max,
    input  logic signed [swms_pkg::SAMPLE_W-1:0] prev_min,
    output logic signed [swms_pkg::SAMPLE_W-1:0] cell_max,
    output logic signed [swms_pkg::SAMPLE_W-1:0] cell_min
);
    import swms_pkg::*;

    logic signed [SAMPLE_W-1:0] max_reg;
    logic signed [SAMPLE_W-1:0] max_next;
    logic signed [SAMPLE_W-1:0] min_reg;
    logic signed [SAMPLE_W-1:0] min_next;

    // fold the new sample into the neighbor's suffix
    always_comb
    begin
        max_next = (prev_max < sample) ? sample : prev_max;
        min_next = (sample < prev_min) ? sample : prev_min;
    end

    // contents matter only once enough samples have passed, so no reset
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            max_reg <= max_next;
            min_reg <= min_next;
        end
    end

    assign cell_max = max_reg;
    assign cell_min = min_reg;

endmodule

>>> rtl/core/swms_tap_tree.sv
// ----------------------------------------------------------------------------
// swms_tap_tree
// Picks the max and min of the tapped cell through a two-level registered
// OR tree and forms the spread; carries the item tag alongside.
// ----------------------------------------------------------------------------
module swms_tap_tree #(
    parameter int WINDOW_MAX = swms_pkg::WINDOW_MAX_DEF,
    parameter int IDX_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 adv,
    input  logic [IDX_W-1:0]                     tap,
    input  logic signed [swms_pkg::SAMPLE_W-1:0] cell_max [WINDOW_MAX],
    input  logic signed [swms_pkg::SAMPLE_W-1:0] cell_min [WINDOW_MAX],
    input  swms_pkg::swms_tag_t                  tag_in,
    output swms_pkg::swms_tag_t                  tag_out,
    output logic [swms_pkg::SAMPLE_W-1:0]        spread
);
    import swms_pkg::*;

    localparam int N_GRP = (WINDOW_MAX + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int N_PAD = N_GRP * GROUP_SIZE;

    logic [SAMPLE_W-1:0] pad_max [N_PAD];
    logic [SAMPLE_W-1:0] pad_min [N_PAD];
    logic [N_PAD-1:0]    pad_sel;

    logic [SAMPLE_W-1:0] grp_max_next [N_GRP];
    logic [SAMPLE_W-1:0] grp_min_next [N_GRP];
    logic [SAMPLE_W-1:0] grp_max_reg  [N_GRP];
    logic [SAMPLE_W-1:0] grp_min_reg  [N_GRP];

    logic [SAMPLE_W-1:0] all_max;
    logic [SAMPLE_W-1:0] all_min;
    logic [SAMPLE_W-1:0] spread_next;
    logic [SAMPLE_W-1:0] spread_reg;

    swms_tag_t tag_a_reg;
    swms_tag_t tag_b_reg;
    swms_tag_t tag_c_reg;

    // one-hot tap flags, padded to whole groups
    for (genvar k = 0; k < N_PAD; k++)
    begin : g_pad
        if (k < WINDOW_MAX)
        begin : g_real
            assign pad_sel[k] = (tap == IDX_W'(k));
            assign pad_max[k] = cell_max[k];
            assign pad_min[k] = cell_min[k];
        end
        else
        begin : g_fill
            assign pad_sel[k] = 1'b0;
            assign pad_max[k] = '0;
            assign pad_min[k] = '0;
        end
    end

    // first level: masked OR inside each group
    for (genvar g = 0; g < N_GRP; g++)
    begin : g_grp
        always_comb
        begin
            grp_max_next[g] = '0;
            grp_min_next[g] = '0;
            for (int i = 0; i < GROUP_SIZE; i++)
            begin
                if (pad_sel[g*GROUP_SIZE + i])
                begin
                    grp_max_next[g] = grp_max_next[g] | pad_max[g*GROUP_SIZE + i];
                    grp_min_next[g] = grp_min_next[g] | pad_min[g*GROUP_SIZE + i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            grp_max_reg <= grp_max_next;
            grp_min_reg <= grp_min_next;
        end
    end

    // second level: OR across groups, then the spread
    always_comb
    begin
        all_max = '0;
        all_min = '0;
        for (int g = 0; g < N_GRP; g++)
        begin
            all_max = all_max | grp_max_reg[g];
            all_min = all_min | grp_min_reg[g];
        end
        spread_next = all_max - all_min;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            spread_reg <= spread_next;
        end
    end

    // tag pipeline: cells, group registers, spread register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            tag_c_reg <= '0;
        end
        else if (adv)
        begin
            tag_a_reg <= tag_in;
            tag_b_reg <= tag_a_reg;
            tag_c_reg <= tag_b_reg;
        end
    end

    assign tag_out = tag_c_reg;
    assign spread  = spread_reg;

endmodule

>>> rtl/core/sliding_window_max_spread_unit.sv
// The last item of a set passes the cells, tap tree and result register.
// Throughput: one sample per cycle; input stalls only while a result waits.
// The rate is set by the suffix cell chain, which updates every cell per item,
// followed by a two-level registered tap tree and the best-spread register.
// Reset clears control state and the window length to 1; cell contents are
// not cleared, since a cell is read only after enough samples refill it.
// ----------------------------------------------------------------------------
// sliding_window_max_spread_unit
// Largest peak-to-peak spread over all windows of a sample set, emitted on
// the last sample of the set.
// ----------------------------------------------------------------------------
`include "sliding_window_max_spread_unit_assert.svh"

module sliding_window_max_spread_unit #(
    parameter int WINDOW_MAX = swms_pkg::WINDOW_MAX_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  swms_pkg::swms_item_t             item,
    output logic                             result_valid,
    input  logic                             result_ready,
    output swms_pkg::swms_result_t           result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [swms_pkg::LEN_W-1:0]       cfg_data
);
    import swms_pkg::*;

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    logic                adv;
    logic                accept;

    logic [LEN_W-1:0]    window_length_reg;
    logic [LEN_W-1:0]    len_eff;
    logic [IDX_W-1:0]    tap;

    logic [LEN_W-1:0]    seen_reg;
    logic [LEN_W-1:0]    seen_next;
    logic [LEN_W-1:0]    seen_clamp;
    logic [LEN_W-1:0]    seen_inc;
    logic                hit;

    logic signed [SAMPLE_W-1:0] cell_max [WINDOW_MAX];
    logic signed [SAMPLE_W-1:0] cell_min [WINDOW_MAX];

    swms_tag_t           tag_in;
    swms_tag_t           tag_c;
    logic [SAMPLE_W-1:0] spread;

    logic [SAMPLE_W-1:0] best_reg;
    logic [SAMPLE_W-1:0] best_next;
    logic                any_reg;
    logic                any_next;
    logic [SAMPLE_W-1:0] cand_best;
    logic                cand_any;

    swms_result_t        result_reg;
    swms_result_t        result_next;
    logic                result_valid_reg;
    logic                result_valid_next;

    // whole pipeline moves unless a result is held back
    assign adv        = !result_valid_reg || result_ready;
    assign item_ready = adv;
    assign accept     = item_valid && adv;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= LEN_RESET;
        end
        else if (cfg_valid)
        begin
            window_length_reg <= cfg_data;
        end
    end

    // effective window length and the tapped cell
    always_comb
    begin
        if (window_length_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (32'(window_length_reg) > 32'(WINDOW_MAX))
        begin
            len_eff = LEN_W'(WINDOW_MAX);
        end
        else
        begin
            len_eff = window_length_reg;
        end
        tap = IDX_W'(len_eff - LEN_W'(1));
    end

    // sample count, clamped to the current window length
    always_comb
    begin
        seen_clamp = (seen_reg > len_eff) ? len_eff : seen_reg;
        seen_inc   = (seen_clamp < len_eff) ? seen_clamp + LEN_W'(1) : seen_clamp;
        hit        = (seen_inc == len_eff);
        seen_next  = seen_reg;
        if (accept)
        begin
            seen_next = item.last ? '0 : seen_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else
        begin
            seen_reg <= seen_next;
        end
    end

    // suffix cell chain; the head cell folds the sample with itself
    for (genvar k = 0; k < WINDOW_MAX; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            swms_cell u_cell (
                .clk      (clk),
                .en       (accept),
                .sample   (item.sample),
                .prev_max (item.sample),
                .prev_min (item.sample),
                .cell_max (cell_max[k]),
                .cell_min (cell_min[k])
            );
        end
        else
        begin : g_body
            swms_cell u_cell (
                .clk      (clk),
                .en       (accept),
                .sample   (item.sample),
                .prev_max (cell_max[k-1]),
                .prev_min (cell_min[k-1]),
                .cell_max (cell_max[k]),
                .cell_min (cell_min[k])
            );
        end
    end

    // tap selection and spread
    assign tag_in = '{valid: accept, hit: hit, last: item.last};

    swms_tap_tree #(
        .WINDOW_MAX (WINDOW_MAX),
        .IDX_W      (IDX_W)
    ) u_tap_tree (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .tap      (tap),
        .cell_max (cell_max),
        .cell_min (cell_min),
        .tag_in   (tag_in),
        .tag_out  (tag_c),
        .spread   (spread)
    );

    // best spread tracking and result register
    always_comb
    begin
        cand_best = best_reg;
        cand_any  = any_reg;
        if (adv && tag_c.valid && tag_c.hit)
        begin
            if (!any_reg || (spread > best_reg))
            begin
                cand_best = spread;
            end
            cand_any = 1'b1;
        end

        best_next         = cand_best;
        any_next          = cand_any;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;

        if (adv && tag_c.valid && tag_c.last)
        begin
            result_next       = '{best_spread: cand_best, window_seen: cand_any};
            result_valid_next = 1'b1;
            best_next         = '0;
            any_next          = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg         <= '0;
            any_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            best_reg         <= best_next;
            any_reg          <= any_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // checks
    `SWMS_ASSERT_IMPL(a_stall_blocks_input, result_valid && !result_ready, !item_ready)
    `SWMS_ASSERT_NEXT(a_last_clears_count, item_valid && item_ready && item.last, seen_reg == '0)
    `SWMS_ASSERT_IMPL(a_no_window_zero, result_valid && !result.window_seen, result.best_spread == '0)
    `SWMS_ASSERT_IMPL(a_result_from_last, $rose(result_valid), $past(tag_c.valid && tag_c.last))

endmodule

>>> verif/sliding_window_max_spread_unit_tb.sv
// ----------------------------------------------------------------------------
// sliding_window_max_spread_unit_tb
// Streams signed sample sets into the unit and checks each emitted spread
// against a cycle-free predictor of the suffix cell chain. Directed sets hit
// the sample extremes and the window length corner cases. Random sets then
// run under three idling mixes, and a long receiver stall fills the unit.
// ----------------------------------------------------------------------------
module sliding_window_max_spread_unit_tb;

    import swms_pkg::*;

    localparam int WIN_CELLS   = WINDOW_MAX_DEF;
    localparam int LATENCY     = 3;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S_MIN = 32'h8000_0000;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               item_valid   = 1'b0;
    logic               item_ready;
    swms_item_t         item         = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    swms_result_t       result;
    logic               cfg_valid    = 1'b0;
    logic               cfg_ready;
    logic [LEN_W-1:0]   cfg_data     = '0;

    // predictor state
    logic signed [31:0] run_max [WIN_CELLS];
    logic signed [31:0] run_min [WIN_CELLS];
    int unsigned        fill_count;
    logic [31:0]        peak_spread;
    bit                 window_hit;
    logic [LEN_W-1:0]   window_reg;

    swms_result_t       pending_spreads [$];
    swms_result_t       want;

    int mismatches  = 0;
    int cycle_count = 0;
    int items_sent  = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int stall_left  = 0;

    sliding_window_max_spread_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void clear_set();
        foreach (run_max[k])
        begin
            run_max[k] = '0;
            run_min[k] = '0;
        end
        fill_count  = 0;
        peak_spread = '0;
        window_hit  = 1'b0;
    endfunction

    // zero acts as one, oversize saturates at the cell count
    function automatic int unsigned eff_window();
        int unsigned n;
        n = window_reg;
        if (n == 0)
            n = 1;
        if (n > WIN_CELLS)
            n = WIN_CELLS;
        return n;
    endfunction

    function automatic void predict_spread(input swms_item_t it);
        int unsigned  len;
        logic [31:0]  spread;
        swms_result_t r;
        len = eff_window();
        // shift the suffix chain, all cells at once
        for (int k = WIN_CELLS - 1; k > 0; k--)
        begin
            run_max[k] = (run_max[k-1] < it.sample) ? it.sample : run_max[k-1];
            run_min[k] = (it.sample < run_min[k-1]) ? it.sample : run_min[k-1];
        end
        run_max[0] = it.sample;
        run_min[0] = it.sample;
        if (fill_count > len)
            fill_count = len;
        if (fill_count < len)
            fill_count++;
        if (fill_count == len)
        begin
            spread = run_max[len-1] - run_min[len-1];
            if (!window_hit || spread > peak_spread)
                peak_spread = spread;
            window_hit = 1'b1;
        end
        if (it.last)
        begin
            r.best_spread = peak_spread;
            r.window_seen = window_hit;
            pending_spreads.push_back(r);
            clear_set();
        end
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random ready, or a counted hold-off
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            result_ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
            result_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("ERROR cycle %0d: %s got %h exp %h", cycle_count, what, got, exp_val);
        mismatches++;
    endtask

    // result check against the oldest predicted spread
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_spreads.size() == 0)
                report_mismatch("unexpected result", result.best_spread, '0);
            else
            begin
                want = pending_spreads.pop_front();
                if (result.best_spread !== want.best_spread)
                    report_mismatch("best_spread", result.best_spread, want.best_spread);
                if (result.window_seen !== want.window_seen)
                    report_mismatch("window_seen", result.window_seen, want.window_seen);
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic push_sample(input logic [31:0] value, input bit is_last);
        swms_item_t it;
        it.sample = value;
        it.last   = is_last;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (!item_ready);
        predict_spread(it);
        items_sent++;
    endtask

    // wait until the unit holds no work, then let the pipeline drain
    task automatic settle();
        item_valid <= 1'b0;
        while (pending_spreads.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_window(input logic [LEN_W-1:0] len);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do
            @(posedge clk);
        while (!cfg_ready);
        window_reg = len;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return S_MAX;
            1: return S_MIN;
            2: return 32'($urandom_range(0, 200)) - 32'd100;
            3: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        int roll;
        roll = $urandom_range(0, 39);
        if (roll == 0)
            return '0;
        else if (roll == 1)
            return LEN_W'(WIN_CELLS);
        else if (roll == 2)
            return LEN_W'($urandom_range(WIN_CELLS + 1, 511));
        else if (roll < 8)
            return LEN_W'($urandom_range(9, 64));
        else
            return LEN_W'($urandom_range(1, 8));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // window length still at its reset value of one
    task automatic test_reset_length();
        push_sample(32'd5, 1'b0);
        push_sample(S_MIN, 1'b0);
        push_sample(S_MAX, 1'b1);
    endtask

    task automatic test_extremes();
        settle();
        write_window(LEN_W'(2));
        push_sample(S_MAX, 1'b0);
        push_sample(S_MIN, 1'b1);
        settle();
        write_window(LEN_W'(3));
        push_sample(32'hFFFF_FFFF, 1'b0);
        push_sample(32'd0, 1'b0);
        push_sample(32'd1, 1'b1);
    endtask

    task automatic test_zero_length();
        settle();
        write_window('0);
        push_sample(32'd7, 1'b0);
        push_sample(32'hFFFF_FFF0, 1'b1);
    endtask

    task automatic test_oversize_length();
        settle();
        write_window(9'h1FF);
        push_sample(S_MIN, 1'b0);
        push_sample(S_MAX, 1'b0);
        push_sample(32'd3, 1'b1);
    endtask

    // sets that never fill a window, one of a single sample
    task automatic test_short_set();
        settle();
        write_window(LEN_W'(5));
        push_sample(32'd10, 1'b0);
        push_sample(32'hFFFF_FF00, 1'b0);
        push_sample(32'd20, 1'b1);
        push_sample(S_MAX, 1'b1);
    endtask

    // window shrinks, then grows, inside one set
    task automatic test_midset_change();
        settle();
        write_window(LEN_W'(4));
        push_sample(32'd100, 1'b0);
        push_sample(32'hFFFF_FF9C, 1'b0);
        push_sample(32'd50, 1'b0);
        settle();
        write_window(LEN_W'(2));
        push_sample(32'd60, 1'b0);
        settle();
        write_window(LEN_W'(6));
        push_sample(32'd0, 1'b0);
        push_sample(32'd1, 1'b1);
    endtask

    task automatic test_random_sets(input int tx_pct, input int rx_pct, input int budget);
        int first;
        int set_len;
        int set_cnt;
        int cut;
        int unsigned len;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        first = items_sent;
        while (items_sent - first < budget)
        begin
            settle();
            write_window(pick_length());
            len = eff_window();
            set_cnt = (len > 16) ? 1 : 3;
            repeat (set_cnt)
            begin
                if (len > 16)
                    set_len = $urandom_range(len - 2, len + 6);
                else
                    set_len = $urandom_range(1, 2 * len + 4);
                // now and then the window changes partway through a set
                cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, set_len) : 0;
                for (int i = 0; i < set_len; i++)
                begin
                    if (cut != 0 && i == cut)
                    begin
                        settle();
                        write_window(pick_length());
                    end
                    push_sample(rand_sample(), i == set_len - 1);
                end
            end
        end
    endtask

    // receiver holds off while short sets keep arriving
    task automatic test_backpressure();
        settle();
        write_window(LEN_W'(2));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        stall_left  = 200;
        repeat (20)
        begin
            push_sample(rand_sample(), 1'b0);
            push_sample(rand_sample(), 1'b1);
        end
    endtask

    initial
    begin
        tx_idle_pct = 35;
        rx_idle_pct = 53;
        window_reg  = LEN_RESET;
        clear_set();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_length();
        test_extremes();
        test_zero_length();
        test_oversize_length();
        test_short_set();
        test_midset_change();
        test_random_sets(35, 53, 330);
        test_random_sets(53, 35, 330);
        test_random_sets(0, 0, 330);
        test_backpressure();

        settle();
        repeat (LATENCY + 4) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/swms_pkg.sv
rtl/core/swms_cell.sv
rtl/core/swms_tap_tree.sv
rtl/core/sliding_window_max_spread_unit.sv
verif/sliding_window_max_spread_unit_tb.sv
